[design/btmx_pkg.sv]
// ----------------------------------------------------------------------------
// btmx_pkg: shared types and constants for the binary trie max-xor block
// Node entry layout, per-level path cell, request/response structs, codes.
// ----------------------------------------------------------------------------
`default_nettype none

package btmx_pkg;

  localparam int KEY_BITS   = 31;
  localparam int NODE_POOL  = 65536;
  localparam int COUNT_BITS = 20;

  localparam int NODE_BITS = $clog2(NODE_POOL);
  localparam int FREE_BITS = $clog2(NODE_POOL + 1);
  localparam int LVL_BITS  = $clog2(KEY_BITS);
  localparam int NEED_BITS = $clog2(KEY_BITS + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_ERASE  = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_POOL_FULL  = 3'd1;
  localparam logic [2:0] ST_KEY_ABSENT = 3'd2;
  localparam logic [2:0] ST_SET_EMPTY  = 3'd3;
  localparam logic [2:0] ST_COUNT_FULL = 3'd4;

  typedef struct packed {
    logic [COUNT_BITS-1:0] cnt;
    logic [NODE_BITS-1:0]  zc;
    logic [NODE_BITS-1:0]  oc;
  } entry_t;

  typedef struct packed {
    logic                 ex;
    logic [NODE_BITS-1:0] id;
    entry_t               ent;
  } cell_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [30:0] key;
  } req_t;

  typedef struct packed {
    logic [30:0] answer;
    logic [2:0]  status;
  } rsp_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_DT   = 9'b000000100,
    S_DEC  = 9'b000001000,
    S_COM  = 9'b000010000,
    S_QOPP = 9'b000100000,
    S_QCHK = 9'b001000000,
    S_QOWN = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  function automatic logic [NODE_BITS-1:0] child_of(entry_t e, logic b);
    return b ? e.oc : e.zc;
  endfunction

  function automatic entry_t set_child(entry_t e, logic b, logic [NODE_BITS-1:0] c);
    entry_t r;
    r = e;
    if (b) r.oc = c;
    else r.zc = c;
    return r;
  endfunction

endpackage

`default_nettype wire

[design/btmx_cell.sv]
// ----------------------------------------------------------------------------
// btmx_cell: one level of the path chain
// Holds the node id and entry seen at one trie level; passes it on when shifting.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_cell (
  input  wire logic           clk,
  input  wire logic           shift,
  input  wire btmx_pkg::cell_t din,
  output btmx_pkg::cell_t     dout
);

  btmx_pkg::cell_t held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= din;
    end
  end

  assign dout = held;

endmodule

`default_nettype wire

[design/binary_trie_max_xor.sv]
// ----------------------------------------------------------------------------
// binary_trie_max_xor: multiset of keys in a binary trie with max-xor query
// Root in flops, other nodes in a node memory with one read and one write port, path in a cell chain.
// ----------------------------------------------------------------------------
//   channel | signals                  | carries
//   request | req_valid, req_ready, req | kind, key
//   result  | rsp_valid, rsp_ready, rsp | answer, status
//
// Insert/erase: each level is walked with a read state and a data state (memory read
// latency), then one decide state, then a commit pass over the path from the top.
// Query: each level tries the opposite child, then the own one; a broken path ends early.
// One request in flight; a new one is taken while the previous result waits.
// Reset clears the root and allocator at once; no clearing pass is needed.
`default_nettype none

module binary_trie_max_xor (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire btmx_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output btmx_pkg::rsp_t      rsp
);

  localparam int KB = btmx_pkg::KEY_BITS;
  localparam int NB = btmx_pkg::NODE_BITS;
  localparam int FB = btmx_pkg::FREE_BITS;
  localparam int LB = btmx_pkg::LVL_BITS;
  localparam int DB = btmx_pkg::NEED_BITS;
  localparam logic [LB-1:0] LVL_TOP = LB'(KB - 1);

  btmx_pkg::state_t state;
  btmx_pkg::entry_t mem [btmx_pkg::NODE_POOL];
  btmx_pkg::entry_t rd_data;
  btmx_pkg::entry_t root;
  btmx_pkg::entry_t par;
  btmx_pkg::entry_t wd;
  btmx_pkg::cell_t  chain [KB];
  btmx_pkg::cell_t  push;
  btmx_pkg::cell_t  head;

  logic [1:0]    kind;
  logic [KB-1:0] key;
  logic [LB-1:0] lvl;
  logic [LB-1:0] lvl_m1;
  logic [NB-1:0] ra, wa, cid;
  logic          we, cex, par_ok, shift;
  logic          full, absent, miss;
  logic [DB-1:0] need;
  logic [FB-1:0] next_free, alloc, free_left;
  logic [KB-1:0] acc;
  logic [2:0]    status;
  logic          bit_next;

  assign req_ready = (state == btmx_pkg::S_IDLE);
  assign shift     = (state == btmx_pkg::S_DT) || (state == btmx_pkg::S_COM);
  assign push      = '{ex: cex, id: cid, ent: rd_data};
  assign head      = chain[KB-1];
  assign lvl_m1    = lvl - LB'(1);
  assign bit_next  = key[lvl_m1];
  assign free_left = FB'(btmx_pkg::NODE_POOL) - next_free;

  // path chain: top level enters first and leaves first
  for (genvar i = 0; i < KB; i++) begin : g_cell
    if (i == 0) begin : g_first
      btmx_cell u_cell (.clk(clk), .shift(shift), .din(push), .dout(chain[i]));
    end else begin : g_rest
      btmx_cell u_cell (.clk(clk), .shift(shift), .din(chain[i-1]), .dout(chain[i]));
    end
  end

  // read address and commit write data
  always_comb begin
    ra = '0;
    we = 1'b0;
    wa = head.id;
    wd = head.ent;
    case (state)
      btmx_pkg::S_RD:   ra = par_ok ? btmx_pkg::child_of(par, key[lvl]) : '0;
      btmx_pkg::S_QOPP: ra = btmx_pkg::child_of(par, ~key[lvl]);
      btmx_pkg::S_QCHK: ra = btmx_pkg::child_of(par, key[lvl]);
      btmx_pkg::S_COM: begin
        we = 1'b1;
        if (kind == btmx_pkg::KIND_ERASE) begin
          wd.cnt = head.ent.cnt - 1'b1;
        end else if (head.ex) begin
          wd.cnt = head.ent.cnt + 1'b1;
          // last existing node on the path links to the first new one
          if (need != '0 && DB'(lvl) == need) begin
            wd = btmx_pkg::set_child(wd, bit_next, alloc[NB-1:0]);
          end
        end else begin
          wa = alloc[NB-1:0];
          wd = '{cnt: btmx_pkg::COUNT_BITS'(1), zc: '0, oc: '0};
          if (lvl != '0) wd = btmx_pkg::set_child(wd, bit_next, NB'(alloc + FB'(1)));
        end
      end
      default: ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= btmx_pkg::S_IDLE;
      root      <= '0;
      next_free <= FB'(1);
      rsp_valid <= 1'b0;
    end else begin
      if (state == btmx_pkg::S_FIN && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      if (state == btmx_pkg::S_RD || state == btmx_pkg::S_QOPP) begin
        cid <= ra;
        cex <= (ra != '0);
      end
      case (state)
        btmx_pkg::S_IDLE: begin
          if (req_valid) begin
            kind   <= req.kind;
            key    <= req.key[KB-1:0];
            lvl    <= LVL_TOP;
            par    <= root;
            par_ok <= 1'b1;
            full   <= 1'b0;
            absent <= 1'b0;
            miss   <= 1'b0;
            need   <= '0;
            acc    <= '0;
            status <= btmx_pkg::ST_OK;
            if (req.kind == btmx_pkg::KIND_INSERT || req.kind == btmx_pkg::KIND_ERASE) begin
              state <= btmx_pkg::S_RD;
            end else if (req.kind == btmx_pkg::KIND_QUERY) begin
              if (root.cnt == '0) begin
                status <= btmx_pkg::ST_SET_EMPTY;
                state  <= btmx_pkg::S_FIN;
              end else begin
                state <= btmx_pkg::S_QOPP;
              end
            end else begin
              state <= btmx_pkg::S_FIN;
            end
          end
        end
        btmx_pkg::S_RD: state <= btmx_pkg::S_DT;
        btmx_pkg::S_DT: begin
          if (cex && rd_data.cnt == btmx_pkg::COUNT_MAX) full <= 1'b1;
          if (!cex && !miss) begin
            miss <= 1'b1;
            need <= DB'(lvl) + DB'(1);
          end
          if (!cex || rd_data.cnt == '0) absent <= 1'b1;
          par    <= rd_data;
          par_ok <= cex;
          if (lvl == '0) begin
            state <= btmx_pkg::S_DEC;
          end else begin
            lvl   <= lvl_m1;
            state <= btmx_pkg::S_RD;
          end
        end
        btmx_pkg::S_DEC: begin
          lvl   <= LVL_TOP;
          alloc <= next_free;
          state <= btmx_pkg::S_COM;
          if (kind == btmx_pkg::KIND_INSERT) begin
            if (full || root.cnt == btmx_pkg::COUNT_MAX) begin
              status <= btmx_pkg::ST_COUNT_FULL;
              state  <= btmx_pkg::S_FIN;
            end else if (FB'(need) > free_left) begin
              status <= btmx_pkg::ST_POOL_FULL;
              state  <= btmx_pkg::S_FIN;
            end else if (need == DB'(KB)) begin
              root <= btmx_pkg::set_child('{cnt: root.cnt + 1'b1, zc: root.zc, oc: root.oc},
                                          key[KB-1], next_free[NB-1:0]);
            end else begin
              root.cnt <= root.cnt + 1'b1;
            end
          end else begin
            if (absent || root.cnt == '0) begin
              status <= btmx_pkg::ST_KEY_ABSENT;
              state  <= btmx_pkg::S_FIN;
            end else begin
              root.cnt <= root.cnt - 1'b1;
            end
          end
        end
        btmx_pkg::S_COM: begin
          if (kind == btmx_pkg::KIND_INSERT && !head.ex) alloc <= alloc + FB'(1);
          if (lvl == '0) begin
            if (kind == btmx_pkg::KIND_INSERT) begin
              next_free <= (head.ex) ? alloc : alloc + FB'(1);
            end
            state <= btmx_pkg::S_FIN;
          end else begin
            lvl <= lvl_m1;
          end
        end
        btmx_pkg::S_QOPP: state <= btmx_pkg::S_QCHK;
        btmx_pkg::S_QCHK: begin
          if (cex && rd_data.cnt != '0) begin
            acc[lvl] <= 1'b1;
            par      <= rd_data;
            if (lvl == '0) begin
              state <= btmx_pkg::S_FIN;
            end else begin
              lvl   <= lvl_m1;
              state <= btmx_pkg::S_QOPP;
            end
          end else if (ra == '0) begin
            // broken path: keep the bits found so far
            state <= btmx_pkg::S_FIN;
          end else begin
            state <= btmx_pkg::S_QOWN;
          end
        end
        btmx_pkg::S_QOWN: begin
          par <= rd_data;
          if (lvl == '0) begin
            state <= btmx_pkg::S_FIN;
          end else begin
            lvl   <= lvl_m1;
            state <= btmx_pkg::S_QOPP;
          end
        end
        btmx_pkg::S_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.answer <= 31'(acc);
            rsp.status <= status;
            state      <= btmx_pkg::S_IDLE;
          end
        end
        default: state <= btmx_pkg::S_IDLE;
      endcase
    end
  end

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    next_free != '0 && next_free <= FB'(btmx_pkg::NODE_POOL))
    else $error("allocator out of range");

  a_erase_path: assert property (@(posedge clk) disable iff (rst)
    (state == btmx_pkg::S_COM && kind == btmx_pkg::KIND_ERASE) |-> head.ex)
    else $error("erase commit on missing node");

  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == btmx_pkg::S_FIN))
    else $error("result raised outside finish");

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    (state == btmx_pkg::S_COM) |-> alloc <= FB'(btmx_pkg::NODE_POOL))
    else $error("allocation beyond pool");

endmodule

`default_nettype wire
